// File: rtl/nti_pkg.sv
// Shared types, constants and helpers for the nonuniform trapezoid integrator.
// Used by every module of the block but the checker; depends on nothing.
`default_nettype none

package nti_pkg;

  localparam int XW = 32;
  localparam int AW = 64;

  localparam logic [AW-1:0] POS_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic [AW-1:0] NEG_MIN = {1'b1, {(AW-1){1'b0}}};

  typedef enum logic [1:0] {
    CFG_LIMIT_MODE  = 2'd0,
    CFG_LOWER_LIMIT = 2'd1,
    CFG_UPPER_LIMIT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic                 limit_mode;
    logic signed [XW-1:0] lower_limit;
    logic signed [XW-1:0] upper_limit;
  } cfg_t;

  // magnitude operands of one term; zero mag_y means no contribution
  typedef struct packed {
    logic          neg;
    logic [XW-1:0] mag_y;
    logic [XW-1:0] mag_dx;
  } opnd_t;

  typedef struct packed {
    logic valid;
    logic last;
  } ctrl_t;

  typedef struct packed {
    logic [AW-1:0] integral;
    logic          saturated;
  } res_t;

  typedef struct packed {
    logic [AW-1:0] sum;
    logic          ovf;
  } sat_sum_t;

  function automatic sat_sum_t sat_add(logic [AW-1:0] a, logic [AW-1:0] b);
    sat_sum_t      r;
    logic [AW-1:0] s;
    s     = a + b;
    r.ovf = (a[AW-1] == b[AW-1]) && (s[AW-1] != a[AW-1]);
    r.sum = r.ovf ? (a[AW-1] ? NEG_MIN : POS_MAX) : s;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/nti_front.sv
// Sample sequencer: tracks previous/pending samples, limits and stop state,
// and registers the operands of the two possible terms per beat. Uses nti_pkg.
`default_nettype none

module nti_front import nti_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cfg_t          cfg,
  input  wire logic          in_fire,
  input  wire logic [XW-1:0] x_value,
  input  wire logic [XW-1:0] y_value,
  input  wire logic          last_sample,
  output opnd_t              op_a_r,
  output opnd_t              op_b_r,
  output ctrl_t              ctrl_r
);

  logic          seen_r, seen_nxt;
  logic          stopped_r, stopped_nxt;
  logic [XW-1:0] older_x_r, older_x_nxt;
  logic [XW-1:0] pending_x_r, pending_x_nxt;
  logic [XW-1:0] pending_y_r, pending_y_nxt;
  opnd_t         op_a_nxt, op_b_nxt;

  logic          a_fin, a_act, b_act, stop1;
  logic [XW-1:0] old_b;

  function automatic logic [XW-1:0] abs_val(logic [XW-1:0] v);
    return v[XW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [XW-1:0] abs_diff(logic [XW-1:0] a, logic [XW-1:0] b);
    logic [XW:0] d;
    d = {a[XW-1], a} - {b[XW-1], b};
    return d[XW] ? XW'(~d + 1'b1) : d[XW-1:0];
  endfunction

  always_comb begin
    a_fin = seen_r && !stopped_r;
    a_act = a_fin && (!cfg.limit_mode || ($signed(older_x_r) > $signed(cfg.lower_limit)));
    stop1 = stopped_r ||
            (a_fin && cfg.limit_mode && ($signed(older_x_r) > $signed(cfg.upper_limit)));
    old_b = seen_r ? pending_x_r : x_value;
    b_act = last_sample && !stop1 &&
            (!cfg.limit_mode || ($signed(old_b) > $signed(cfg.lower_limit)));

    op_a_nxt.neg    = pending_y_r[XW-1];
    op_a_nxt.mag_y  = a_act ? abs_val(pending_y_r) : '0;
    op_a_nxt.mag_dx = abs_diff(x_value, older_x_r);
    op_b_nxt.neg    = y_value[XW-1];
    op_b_nxt.mag_y  = b_act ? abs_val(y_value) : '0;
    op_b_nxt.mag_dx = abs_diff(x_value, old_b);

    seen_nxt      = seen_r;
    stopped_nxt   = stopped_r;
    older_x_nxt   = older_x_r;
    pending_x_nxt = pending_x_r;
    pending_y_nxt = pending_y_r;
    if (in_fire) begin
      older_x_nxt   = old_b;
      pending_x_nxt = x_value;
      pending_y_nxt = y_value;
      seen_nxt      = !last_sample;
      stopped_nxt   = stop1 && !last_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= 1'b0;
      stopped_r    <= 1'b0;
      older_x_r    <= '0;
      pending_x_r  <= '0;
      pending_y_r  <= '0;
      ctrl_r.valid <= 1'b0;
    end else begin
      seen_r       <= seen_nxt;
      stopped_r    <= stopped_nxt;
      older_x_r    <= older_x_nxt;
      pending_x_r  <= pending_x_nxt;
      pending_y_r  <= pending_y_nxt;
      ctrl_r.valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    ctrl_r.last <= last_sample;
    op_a_r      <= op_a_nxt;
    op_b_r      <= op_b_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/nti_term.sv
// One trapezoid term: |y|*|dx| product, then scale to Q32.32 (including /2)
// with rounding or saturation, and sign. Two register stages. Uses nti_pkg.
`default_nettype none

module nti_term import nti_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic   clk,
  input  wire opnd_t  op,
  output logic [AW-1:0] term_r,
  output logic          clip_r
);

  localparam int SHIFT = 31 - 2 * FRAC_BITS;

  logic [AW-1:0] prod_r;
  logic          neg_r;
  logic [AW-1:0] scaled;
  logic          sclip;

  always_ff @(posedge clk) begin
    prod_r <= op.mag_y * op.mag_dx;
    neg_r  <= op.neg;
  end

  generate
    if (SHIFT < 0) begin : g_rsh
      localparam int RSH = -SHIFT;
      assign scaled = (prod_r + (AW'(1) << (RSH - 1))) >> RSH;
      assign sclip  = 1'b0;
    end else if (SHIFT > 0) begin : g_lsh
      logic [AW-1:0] lim;
      assign lim    = neg_r ? NEG_MIN : POS_MAX;
      assign sclip  = prod_r > (lim >> SHIFT);
      assign scaled = sclip ? lim : (prod_r << SHIFT);
    end else begin : g_none
      assign scaled = prod_r;
      assign sclip  = 1'b0;
    end
  endgenerate

  always_ff @(posedge clk) begin
    term_r <= neg_r ? (~scaled + 1'b1) : scaled;
    clip_r <= sclip;
  end

endmodule

`default_nettype wire

// File: rtl/nti_accum.sv
// Saturating Q32.32 accumulator with clip tracking; on the last beat adds the
// closing term in a second stage and presents the result. Uses nti_pkg.
`default_nettype none

module nti_accum import nti_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ctrl_t         ctrl,
  input  wire logic [AW-1:0] term_a,
  input  wire logic          clip_a,
  input  wire logic [AW-1:0] term_b,
  input  wire logic          clip_b,
  output res_t               res_r,
  output logic               res_valid_r
);

  logic [AW-1:0] acc_r, acc_nxt;
  logic          clip_r, clip_nxt;
  logic          mid_valid_r;
  logic [AW-1:0] mid_sum_r, mid_term_b_r;
  logic          mid_flag_r;
  sat_sum_t      sum1, sum2;
  logic          flag1;

  always_comb begin
    sum1     = sat_add(acc_r, term_a);
    flag1    = clip_r | clip_a | sum1.ovf;
    acc_nxt  = acc_r;
    clip_nxt = clip_r;
    if (ctrl.valid) begin
      acc_nxt  = ctrl.last ? '0 : sum1.sum;
      clip_nxt = ctrl.last ? 1'b0 : flag1;
    end
    sum2 = sat_add(mid_sum_r, mid_term_b_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      clip_r      <= 1'b0;
      mid_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      clip_r      <= clip_nxt;
      mid_valid_r <= ctrl.valid && ctrl.last;
      res_valid_r <= mid_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    mid_sum_r      <= sum1.sum;
    mid_term_b_r   <= term_b;
    mid_flag_r     <= flag1 | clip_b;
    res_r.integral  <= sum2.sum;
    res_r.saturated <= mid_flag_r | sum2.ovf;
  end

endmodule

`default_nettype wire

// File: rtl/nti_result_fifo.sv
// Result queue between the accumulator and the output channel.
// Register storage, head read from the array. Uses nti_pkg.
`default_nettype none

module nti_result_fifo import nti_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire res_t push_data,
  input  wire logic pop,
  output res_t      head,
  output logic      not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);

endmodule

`default_nettype wire

// File: rtl/nonuniform_trapezoid_integrator.sv
// Streaming trapezoidal integrator over a nonuniform grid: signed Q16.16 (x, y)
// samples in, one saturating Q32.32 sum out per data set, on the last sample.
// One sample is taken every clock while in_stall is low. After the last_sample
// beat the sum passes the operand, multiply, scale, accumulate and closing add
// stages; up to RESULT_DEPTH finished sums wait in a queue, and in_stall rises
// only when that many results are queued or in flight. Limits and mode are
// sampled when a sample is finalized, so write them between data sets.
`default_nettype none

module nonuniform_trapezoid_integrator import nti_pkg::*; #(
  parameter int FRAC_BITS    = 16,
  parameter int RESULT_DEPTH = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [XW-1:0]      cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [XW-1:0] in_x_value,
  input  wire logic signed [XW-1:0] in_y_value,
  input  wire logic               in_last_sample,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [AW-1:0]    out_integral,
  output logic                    out_saturated
);

  localparam int CW = $clog2(RESULT_DEPTH + 1);

  cfg_t          cfg_r;
  logic [CW-1:0] credit_r, credit_nxt;
  logic          in_fire, out_fire;
  opnd_t         op_a, op_b;
  ctrl_t         ctrl_f, ctrl_d1_r, ctrl_d2_r;
  logic [AW-1:0] term_a, term_b;
  logic          clip_a, clip_b;
  res_t          res, head;
  logic          res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.limit_mode  <= 1'b0;
      cfg_r.lower_limit <= '0;
      cfg_r.upper_limit <= {1'b0, {(XW-1){1'b1}}};
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LIMIT_MODE:  cfg_r.limit_mode  <= cfg_wdata[0];
        CFG_LOWER_LIMIT: cfg_r.lower_limit <= cfg_wdata;
        CFG_UPPER_LIMIT: cfg_r.upper_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall = (credit_r == CW'(RESULT_DEPTH));
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  always_comb begin
    case ({in_fire && in_last_sample, out_fire})
      2'b10:   credit_nxt = credit_r + 1'b1;
      2'b01:   credit_nxt = credit_r - 1'b1;
      default: credit_nxt = credit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r        <= '0;
      ctrl_d1_r.valid <= 1'b0;
      ctrl_d2_r.valid <= 1'b0;
    end else begin
      credit_r        <= credit_nxt;
      ctrl_d1_r.valid <= ctrl_f.valid;
      ctrl_d2_r.valid <= ctrl_d1_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    ctrl_d1_r.last <= ctrl_f.last;
    ctrl_d2_r.last <= ctrl_d1_r.last;
  end

  nti_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_fire     (in_fire),
    .x_value     (in_x_value),
    .y_value     (in_y_value),
    .last_sample (in_last_sample),
    .op_a_r      (op_a),
    .op_b_r      (op_b),
    .ctrl_r      (ctrl_f)
  );

  nti_term #(.FRAC_BITS(FRAC_BITS)) u_term_a (
    .clk    (clk),
    .op     (op_a),
    .term_r (term_a),
    .clip_r (clip_a)
  );

  nti_term #(.FRAC_BITS(FRAC_BITS)) u_term_b (
    .clk    (clk),
    .op     (op_b),
    .term_r (term_b),
    .clip_r (clip_b)
  );

  nti_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl_d2_r),
    .term_a      (term_a),
    .clip_a      (clip_a),
    .term_b      (term_b),
    .clip_b      (clip_b),
    .res_r       (res),
    .res_valid_r (res_valid)
  );

  nti_result_fifo #(.DEPTH(RESULT_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop       (out_fire),
    .head      (head),
    .not_empty (out_valid)
  );

  assign out_integral  = head.integral;
  assign out_saturated = head.saturated;

endmodule

`default_nettype wire

// File: rtl/nti_checker.sv
// Port-level checks for the integrator, bound to the top level.
// Depends on nonuniform_trapezoid_integrator.
`default_nettype none

module nti_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_integral,
  input wire logic        out_saturated
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present right after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  // a beat passes the registered pipeline stages before it reaches the output queue
  a_no_instant: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid [*5])
    else $error("result beat too soon after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_integral) && $stable(out_saturated))
    else $error("stalled result beat changed");

endmodule

bind nonuniform_trapezoid_integrator nti_checker u_nti_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_integral  (out_integral),
  .out_saturated (out_saturated)
);

`default_nettype wire
